// ===== hw/rtl/jao_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint admittance offset package
// Shared widths, reset values, register indexes and the packed gain decoder.
// ----------------------------------------------------------------------------
package jao_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [16:0] COEF_ONE         = 17'd65536;
  localparam logic [30:0] MAX_OFFSET_RESET = 31'd65536;
  localparam logic [47:0] STIFF_RESET      = 48'h0100_0100_0100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_COEF,
    REG_DEADBAND,
    REG_MAX_OFFSET,
    REG_DAMP_LOW,
    REG_DAMP_HIGH,
    REG_STIFF_LOW,
    REG_STIFF_HIGH
  } cfg_reg_t;

  // Each register packs three signed Q8.8 gains; axes without a field read zero.
  function automatic logic [GAIN_W-1:0] packed_gain(
    input logic [CFG_W-1:0] low,
    input logic [CFG_W-1:0] high,
    input logic [2:0]       axis
  );
    logic [GAIN_W-1:0] g;
    unique case (axis)
      3'd0:    g = low[15:0];
      3'd1:    g = low[31:16];
      3'd2:    g = low[47:32];
      3'd3:    g = high[15:0];
      3'd4:    g = high[31:16];
      3'd5:    g = high[47:32];
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== hw/rtl/joint_admittance_offset_unit.sv =====
// ----------------------------------------------------------------------------
// Joint admittance offset unit
// Filters the wrench of one axis and turns it into a clamped position offset.
// ----------------------------------------------------------------------------
// Each input transfer carries an axis, a raw wrench, a joint position and a
// joint velocity; each one yields exactly one output transfer with the command
// position and an active flag. Both channels use valid and ready. Gains, the
// filter coefficient, the deadband and the offset limit are set through the
// write-only configuration port; the user must write them only while the unit
// is idle, and the unit itself does not enforce this.
// The two products are formed by shift-and-add multipliers that take one
// multiplier bit per cycle, and the quotient comes from a restoring divider
// that makes one quotient bit per cycle. An item without an offset, or whose
// offset saturates, skips the divider. One item is in work at a time. A
// finished result sits in the output register, and the next item is taken
// while it waits; a stalled receiver only holds back the item after that.
// Synchronous reset clears the filter state of all axes and restores the
// configuration reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module joint_admittance_offset_unit
  import jao_pkg::*;
#(
  parameter int unsigned AXES = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_axis,
  input  logic signed [DATA_W-1:0] in_raw_wrench,
  input  logic signed [DATA_W-1:0] in_joint_position,
  input  logic signed [DATA_W-1:0] in_joint_velocity,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_command_position,
  output logic                     out_offset_active,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  localparam int unsigned AW     = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [3:0]  AXES_V = 4'(AXES);
  localparam logic [4:0]  MUL_LAST = 5'd16;
  localparam logic [4:0]  DIV_LAST = 5'd30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FILT,
    ST_TERM,
    ST_PREP,
    ST_DIV,
    ST_OFFS,
    ST_DONE
  } state_t;

  state_t st_r;

  logic [16:0]        coef_r;
  logic [30:0]        deadband_r;
  logic [30:0]        max_offset_r;
  logic [CFG_W-1:0]   damp_low_r;
  logic [CFG_W-1:0]   damp_high_r;
  logic [CFG_W-1:0]   stiff_low_r;
  logic [CFG_W-1:0]   stiff_high_r;

  logic signed [DATA_W-1:0] sw_r [AXES];

  logic              axis_ok_r;
  logic [AW-1:0]     idx_r;
  logic signed [31:0] pos_r;
  logic signed [31:0] s_r;
  logic [49:0]       mc_f_r;
  logic [16:0]       mp_f_r;
  logic [49:0]       acc_f_r;
  logic [47:0]       mc_d_r;
  logic [15:0]       mp_d_r;
  logic [47:0]       acc_d_r;
  logic [4:0]        cnt_r;
  logic [15:0]       k_r;
  logic [15:0]       kmag_r;
  logic signed [31:0] f_r;
  logic [48:0]       term_r;
  logic              active_r;
  logic              neg_r;
  logic              sat_r;
  logic [15:0]       rem_r;
  logic [30:0]       dvd_r;
  logic [30:0]       q_r;
  logic [31:0]       off_r;
  logic              out_valid_r;
  logic [31:0]       out_cmd_r;
  logic              out_act_r;

  logic              axis_ok;
  logic [AW-1:0]     in_idx;
  logic [31:0]       s_rd;
  logic [16:0]       coef_eff;
  logic [32:0]       diff;
  logic [49:0]       acc_f_nxt;
  logic [47:0]       acc_d_nxt;
  logic [33:0]       filt_sum;
  logic [31:0]       f_nxt;
  logic [48:0]       term_nxt;
  logic [48:0]       term_mag;
  logic [31:0]       f_mag;
  logic [15:0]       kmag_nxt;
  logic              ovf;
  logic              active_nxt;
  logic [16:0]       rem2;
  logic              q_bit;
  logic [15:0]       rem_nxt;
  logic [30:0]       off_mag;
  logic [31:0]       off_nxt;
  logic [32:0]       cmd_sum;
  logic [31:0]       cmd_nxt;

  assign axis_ok  = {1'b0, in_axis} < AXES_V;
  assign in_idx   = in_axis[AW-1:0];
  assign s_rd     = axis_ok ? sw_r[in_idx] : '0;
  assign coef_eff = (coef_r > COEF_ONE) ? COEF_ONE : coef_r;
  assign diff     = {in_raw_wrench[31], in_raw_wrench} - {s_rd[31], s_rd};

  always_comb begin
    acc_f_nxt = mp_f_r[0] ? acc_f_r + mc_f_r : acc_f_r;
    if (!mp_d_r[0]) begin
      acc_d_nxt = acc_d_r;
    end else if (cnt_r == 5'd1) begin
      acc_d_nxt = acc_d_r - mc_d_r;
    end else begin
      acc_d_nxt = acc_d_r + mc_d_r;
    end
    filt_sum   = {{2{s_r[31]}}, s_r} + acc_f_r[49:16];
    f_nxt      = filt_sum[31:0];
    term_nxt   = {{9{f_r[31]}}, f_r, 8'd0} - {acc_d_r[47], acc_d_r};
    kmag_nxt   = k_r[15] ? (16'd0 - k_r) : k_r;
    term_mag   = term_r[48] ? (49'd0 - term_r) : term_r;
    f_mag      = f_r[31] ? (32'd0 - f_r) : f_r;
    ovf        = term_mag[47:31] >= {1'b0, kmag_r};
    active_nxt = axis_ok_r && (f_mag >= {1'b0, deadband_r}) && (k_r != 16'd0);
    rem2       = {rem_r, dvd_r[30]};
    q_bit      = rem2 >= {1'b0, kmag_r};
    rem_nxt    = q_bit ? 16'(rem2 - {1'b0, kmag_r}) : rem2[15:0];
    if (!active_r) begin
      off_mag = '0;
    end else if (sat_r || (q_r > max_offset_r)) begin
      off_mag = max_offset_r;
    end else begin
      off_mag = q_r;
    end
    off_nxt = neg_r ? (32'd0 - {1'b0, off_mag}) : {1'b0, off_mag};
    cmd_sum = {pos_r[31], pos_r} + {off_r[31], off_r};
    if (cmd_sum[32] != cmd_sum[31]) begin
      cmd_nxt = cmd_sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      cmd_nxt = cmd_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_valid_r  <= 1'b0;
      coef_r       <= COEF_ONE;
      deadband_r   <= '0;
      max_offset_r <= MAX_OFFSET_RESET;
      damp_low_r   <= '0;
      damp_high_r  <= '0;
      stiff_low_r  <= STIFF_RESET;
      stiff_high_r <= STIFF_RESET;
      for (int i = 0; i < AXES; i++) begin
        sw_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_FILTER_COEF: coef_r       <= cfg_wdata[16:0];
          REG_DEADBAND:    deadband_r   <= cfg_wdata[30:0];
          REG_MAX_OFFSET:  max_offset_r <= cfg_wdata[30:0];
          REG_DAMP_LOW:    damp_low_r   <= cfg_wdata;
          REG_DAMP_HIGH:   damp_high_r  <= cfg_wdata;
          REG_STIFF_LOW:   stiff_low_r  <= cfg_wdata;
          REG_STIFF_HIGH:  stiff_high_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && (st_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            axis_ok_r <= axis_ok;
            idx_r     <= in_idx;
            pos_r     <= in_joint_position;
            s_r       <= s_rd;
            mc_f_r    <= {{17{diff[32]}}, diff};
            mp_f_r    <= coef_eff;
            acc_f_r   <= '0;
            mc_d_r    <= {{16{in_joint_velocity[31]}}, in_joint_velocity};
            mp_d_r    <= packed_gain(damp_low_r, damp_high_r, in_axis);
            acc_d_r   <= '0;
            k_r       <= packed_gain(stiff_low_r, stiff_high_r, in_axis);
            cnt_r     <= MUL_LAST;
            st_r      <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_f_r <= acc_f_nxt;
          acc_d_r <= acc_d_nxt;
          mc_f_r  <= {mc_f_r[48:0], 1'b0};
          mc_d_r  <= {mc_d_r[46:0], 1'b0};
          mp_f_r  <= {1'b0, mp_f_r[16:1]};
          mp_d_r  <= {1'b0, mp_d_r[15:1]};
          cnt_r   <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            st_r <= ST_FILT;
          end
        end
        ST_FILT: begin
          f_r <= f_nxt;
          if (axis_ok_r) begin
            sw_r[idx_r] <= f_nxt;
          end
          st_r <= ST_TERM;
        end
        ST_TERM: begin
          term_r <= term_nxt;
          kmag_r <= kmag_nxt;
          st_r   <= ST_PREP;
        end
        ST_PREP: begin
          active_r <= active_nxt;
          neg_r    <= term_r[48] ^ k_r[15];
          sat_r    <= ovf;
          rem_r    <= term_mag[46:31];
          dvd_r    <= term_mag[30:0];
          q_r      <= '0;
          cnt_r    <= DIV_LAST;
          st_r     <= (active_nxt && !ovf) ? ST_DIV : ST_OFFS;
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[29:0], 1'b0};
          q_r   <= {q_r[29:0], q_bit};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            st_r <= ST_OFFS;
          end
        end
        ST_OFFS: begin
          off_r <= off_nxt;
          st_r  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_cmd_r   <= cmd_nxt;
            out_act_r   <= active_r;
            out_valid_r <= 1'b1;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready             = (st_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_command_position = out_cmd_r;
  assign out_offset_active    = out_act_r;

endmodule

// ===== hw/rtl/jao_checker.sv =====
// ----------------------------------------------------------------------------
// Joint admittance offset checker
// Port-level properties of the unit, attached to every instance by bind.
// ----------------------------------------------------------------------------
module jao_checker
  import jao_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_command_position,
  input logic              out_offset_active
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Input taken while an item is in work.");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("Result appeared right after an input transfer.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_command_position) && $stable(out_offset_active)))
    else $error("Stalled result changed or dropped.");

endmodule

bind joint_admittance_offset_unit jao_checker u_jao_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_command_position (out_command_position),
  .out_offset_active    (out_offset_active)
);
